// ----- hdl/afs_pkg.sv -----
// Shared types and constants for the adaptive frame skip controller.
// Depends on nothing; every other file in hdl imports it.
package afs_pkg;

    // Stream and configuration port widths.
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_COUNT_W = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SKIP_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_RATE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RATE    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_MS   = 2'd3;

    // Configuration reset values.
    localparam logic        RST_SKIP_ENABLE = 1'b1;
    localparam logic [7:0]  RST_MIN_RATE    = 8'd20;
    localparam logic [7:0]  RST_MAX_RATE    = 8'd35;
    localparam logic [15:0] RST_WINDOW_MS   = 16'd1000;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV1,
        ST_DIV2,
        ST_APPLY
    } afs_state_t;

endpackage

// ----- hdl/afs_divider.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on afs_pkg only through the project import convention.
module afs_divider
    import afs_pkg::*;
#(
    parameter int N = 16,
    parameter int D = 12
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic [N-1:0] quotient,
    output logic         done
);

    localparam int CNT_W = $clog2(N + 1);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(N);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [D-1:0]     rem_reg, rem_next;
    logic [N-1:0]     quo_reg, quo_next;
    logic [D-1:0]     div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [D:0]       trial;
    logic             fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign trial = {rem_reg, quo_reg[N-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            cnt_next  = CNT_LOAD;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? D'(trial - {1'b0, div_reg}) : trial[D-1:0];
            quo_next = {quo_reg[N-2:0], fits};
            cnt_next = cnt_reg - CNT_ONE;
            if (cnt_reg == CNT_ONE)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath is loaded on start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- hdl/adaptive_frame_skip_controller.sv -----
// Top level of the adaptive frame skip controller: sequencer, state and ports.
// Depends on afs_pkg and afs_divider.
//
// Usage: each transaction on the s_axis channel is one video frame arrival
// carrying a 32-bit millisecond tick. For every frame one transaction leaves
// on m_axis saying whether the frame is skipped, whether the skip count
// changed, and the skip count now in force. Configuration registers are
// written through cfg_wen/cfg_index/cfg_wdata; the user must write them
// only while no frame is in flight, as the block does not enforce this.
// Sequence: a frame that does not close a window passes the check and apply
// states, and m_axis_tvalid then rises from the output register. A frame that
// closes a window and adapts the count runs the shared divider once or twice
// in the divide states between check and apply.
// Flow control: one frame at a time; s_axis_tready is high only when the
// sequencer is idle, so a new frame waits until the previous one has left
// the apply state, and a window that adapts holds it through the divider passes.
// Reset: the window start, frame counter and skip count clear to zero and
// the registers take their reset values; no result is pending.
// Stall: the result waits in an output register. A new frame is accepted
// and processed meanwhile, and the sequencer holds in its last step until
// the receiver takes the previous result.
module adaptive_frame_skip_controller
    import afs_pkg::*;
#(
    parameter int COUNT_WIDTH = 16,
    parameter int SKIP_WIDTH  = 11
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Frame arrivals. tdata: now_ms[31:0].
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Results. tdata: skip_frame[0], skip_changed[1], skip_count_now[12:2], zero fill.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // Configuration writes.
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int FW = (COUNT_WIDTH > 9) ? COUNT_WIDTH : 9;
    localparam int DW = (SKIP_WIDTH + 1 > 9) ? SKIP_WIDTH + 1 : 9;
    localparam int XW = (COUNT_WIDTH > SKIP_WIDTH) ? COUNT_WIDTH : SKIP_WIDTH;
    localparam int QW = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [SKIP_WIDTH-1:0]  SKIP_MAX  = '1;
    localparam int PAD_W = OUT_TDATA_W - OUT_COUNT_W - 2;

    afs_state_t state_reg, state_next;

    logic                   skip_enable_reg;
    logic [7:0]             min_rate_reg;
    logic [7:0]             max_rate_reg;
    logic [15:0]            window_ms_reg;

    logic [31:0]            win_start_reg;
    logic [COUNT_WIDTH-1:0] frames_reg;
    logic [SKIP_WIDTH-1:0]  skip_reg;
    logic [SKIP_WIDTH-1:0]  phase_reg;

    logic [31:0]            now_reg;
    logic [SKIP_WIDTH-1:0]  s_reg;
    logic                   new_win_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [31:0]            elapsed;
    logic                   win_go;
    logic                   adapt_cond;
    logic [XW-1:0]          raised;
    logic [SKIP_WIDTH-1:0]  s_sat;
    logic                   rate_low;
    logic [SKIP_WIDTH-1:0]  skip_after;
    logic [SKIP_WIDTH-1:0]  phase_after;
    logic                   skip_out;
    logic                   out_free;

    logic                   div_start;
    logic [DW-1:0]          div_divisor;
    logic [COUNT_WIDTH-1:0] div_quotient;
    logic                   div_done;
    logic                   apply_fire;

    // Shared divider: frames / (max_rate + 1), then frames / (count + 1).
    afs_divider #(
        .N(COUNT_WIDTH),
        .D(DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (frames_reg),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // Window end test and the condition for adapting the count.
    assign elapsed    = now_reg - win_start_reg;
    assign win_go     = skip_enable_reg && (elapsed > {16'b0, window_ms_reg});
    assign adapt_cond = (FW'(frames_reg) >= FW'({min_rate_reg, 1'b0})) ||
                        ((FW'(frames_reg) < FW'(max_rate_reg)) && (skip_reg != '0));

    // Raised count: at least the current one, saturated to the count range.
    assign raised = (XW'(div_quotient) > XW'(skip_reg)) ? XW'(div_quotient) : XW'(skip_reg);
    assign s_sat  = (raised > XW'(SKIP_MAX)) ? SKIP_MAX : raised[SKIP_WIDTH-1:0];

    // Back-off test: kept frames per window below the minimum.
    assign rate_low = QW'(div_quotient) < QW'(min_rate_reg);

    // Count and phase after this frame.
    always_comb
    begin
        skip_after  = skip_reg;
        phase_after = phase_reg;
        if (skip_enable_reg)
        begin
            if (new_win_reg)
            begin
                skip_after  = s_reg;
                phase_after = SKIP_WIDTH'(s_reg != '0);
            end
            else if (frames_reg != COUNT_MAX)
            begin
                phase_after = (phase_reg == skip_reg) ? '0 : phase_reg + SKIP_WIDTH'(1);
            end
        end
    end

    assign skip_out = skip_enable_reg && (skip_after != '0) && (phase_after != '0);
    assign out_free = !out_valid_reg || m_axis_tready;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = (win_go && adapt_cond) ? ST_DIV1 : ST_APPLY;
            end
            ST_DIV1:
            begin
                if (div_done)
                    state_next = (s_sat != '0) ? ST_DIV2 : ST_APPLY;
            end
            ST_DIV2:
            begin
                if (div_done)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        div_divisor   = DW'(s_sat) + DW'(1);
        apply_fire    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_CHECK:
            begin
                div_start   = win_go && adapt_cond;
                div_divisor = DW'(max_rate_reg) + DW'(1);
            end
            ST_DIV1:
            begin
                div_start = div_done && (s_sat != '0);
            end
            ST_DIV2:
            begin
                div_start = 1'b0;
            end
            ST_APPLY:
            begin
                apply_fire = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (apply_fire)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // Control state, configuration and block state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            skip_enable_reg <= RST_SKIP_ENABLE;
            min_rate_reg    <= RST_MIN_RATE;
            max_rate_reg    <= RST_MAX_RATE;
            window_ms_reg   <= RST_WINDOW_MS;
            win_start_reg   <= '0;
            frames_reg      <= '0;
            skip_reg        <= '0;
            phase_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_SKIP_ENABLE: skip_enable_reg <= cfg_wdata[0];
                    REG_MIN_RATE:    min_rate_reg    <= cfg_wdata[7:0];
                    REG_MAX_RATE:    max_rate_reg    <= cfg_wdata[7:0];
                    REG_WINDOW_MS:   window_ms_reg   <= cfg_wdata;
                    default:         skip_enable_reg <= skip_enable_reg;
                endcase
            end
            if (apply_fire && skip_enable_reg)
            begin
                skip_reg  <= skip_after;
                phase_reg <= phase_after;
                if (new_win_reg)
                begin
                    win_start_reg <= now_reg;
                    frames_reg    <= COUNT_WIDTH'(1);
                end
                else if (frames_reg != COUNT_MAX)
                begin
                    frames_reg <= frames_reg + COUNT_WIDTH'(1);
                end
            end
        end
    end

    // Per-frame working registers and the result register.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            now_reg <= s_axis_tdata;
        if (state_reg == ST_CHECK)
        begin
            new_win_reg <= win_go;
            s_reg       <= skip_reg;
        end
        if (state_reg == ST_DIV1 && div_done)
            s_reg <= s_sat;
        if (state_reg == ST_DIV2 && div_done && rate_low)
            s_reg <= s_reg - SKIP_WIDTH'(1);
        if (apply_fire)
            out_data_reg <= {{PAD_W{1'b0}}, OUT_COUNT_W'(skip_after),
                             skip_enable_reg && new_win_reg && (s_reg != skip_reg),
                             skip_out};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTH
    // The frame position stays below the skip period.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= skip_reg)
        else $error("frame phase exceeds skip count");

    // After a frame is taken the block is busy in the cycle that follows.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("frame accepted while previous one in progress");

    // A skipped frame always comes with a nonzero skip count.
    a_skip_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[OUT_COUNT_W+1:2] != '0))
        else $error("frame skipped with zero skip count");

    // The divider only reports completion while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV1 || state_reg == ST_DIV2))
        else $error("divider finished outside a divide step");
`endif

endmodule
